### src/mbpe_pkg.sv
// ---------------------------------------------------------------------------
// mbpe_pkg: shared types, constants and functions of the payload encryptor
// Holds the session constants, the result entry type and the CRC, handshake
// and byte-swap helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package mbpe_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned SizeW         = 19;
  localparam int unsigned CrcW          = 16;
  localparam int unsigned KindW         = 2;

  localparam int unsigned MaxImageBytes = 262144;
  localparam int unsigned HeaderBytes   = 192;
  localparam int unsigned MinImageBytes = 512;

  localparam logic [CrcW-1:0]  CrcPoly  = 16'ha1c1;
  localparam logic [CrcW-1:0]  CrcInit  = 16'h15a0;
  localparam logic [WordW-1:0] LcgMul   = 32'h6177614b;
  localparam logic [WordW-1:0] LcgMul2  = WordW'(64'(LcgMul) * 64'(LcgMul));
  localparam logic [WordW-1:0] LcgAdd2  = LcgMul + 32'd1;
  localparam logic [WordW-1:0] KeyXor   = 32'h7365646f;
  localparam logic [WordW-1:0] DataXor  = 32'h20796220;
  localparam logic [WordW-1:0] AddrBase = 32'h02000000;

  // Register byte addresses on the configuration port
  localparam logic [2:0] AddrImageBytes = 3'd0;
  localparam logic [2:0] AddrRawKey     = 3'd4;

  // Output queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [KindW-1:0] {
    KindKey     = 2'd0,
    KindHeader  = 2'd1,
    KindPayload = 2'd2,
    KindSeal    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    kind_e            kind;
    logic             last;
  } result_t;

  function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // LSB-first bit-serial CRC over one word, unrolled into an XOR network
  function automatic logic [CrcW-1:0] crc_word(input logic [CrcW-1:0]  crc_in,
                                               input logic [WordW-1:0] val);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc_in;
    for (int b = 0; b < WordW; b++) begin
      fb = c[0] ^ val[b];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    crc_word = c;
  endfunction

  // Key word announced before the image, derived from the send size
  function automatic logic [WordW-1:0] handshake_key(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] diff;
    logic [15:0]      n;
    logic [WordW-1:0] r2;
    logic [WordW-1:0] r3;
    logic [WordW-1:0] k;
    diff = size - SizeW'(MinImageBytes);
    n    = 16'(diff >> 3);
    r2   = (32'(n & 16'h3f80) << 1) | (32'(n & 16'h4000) << 2) | 32'(n & 16'h007f)
         | 32'h00380000;
    r3   = (r2 >> 8) + (r2 >> 16) + r2;
    r3   = (r3 << 24) | r2 | 32'h80808080;
    if (!r3[9]) begin
      k = {r3[7:0] ^ 8'h4b, r3[15:8] ^ 8'h61, r3[23:16] ^ 8'h77, r3[31:24] ^ 8'h61};
    end else begin
      k = {r3[7:0] ^ 8'h73, r3[15:8] ^ 8'h65, r3[23:16] ^ 8'h64, r3[31:24] ^ 8'h6f};
    end
    handshake_key = k;
  endfunction

endpackage

`default_nettype wire

### src/multiboot_payload_encryptor_unit.sv
// ---------------------------------------------------------------------------
// multiboot_payload_encryptor_unit: boot image stream encryptor
// Turns a stream of image words into the link words of one boot session.
// ---------------------------------------------------------------------------
// Usage:
//   Program image_bytes (address 0x0) and raw_session_key (address 0x4) over
//   the APB port while the block is idle, then stream the image words on the
//   s_axis side, one little-endian 32-bit word per transaction.
//   The first word of a session produces a handshake key word followed by
//   the header word; the last word produces the encrypted word followed by
//   the sealed CRC word. Every other word produces a single link word.
//   m_axis_tuser carries the word kind, m_axis_tlast marks the final link
//   word caused by an input word.
//   A link word is registered in the result queue before it reaches m_axis.
//   Throughput: one input word per cycle while s_axis_tready is high; a
//   word with two results fills two entries ahead of the single output port.
//   All per-word work (CRC network, key multiply) sits between the input
//   handshake and a four-entry result queue.
//   Reset: empties the queue and returns to the start of a session.
//   Output stall: the queue absorbs results; s_axis_tready drops once fewer
//   than two free entries remain, and nothing is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module multiboot_payload_encryptor_unit
  import mbpe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // Image words in
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [WordW-1:0]  s_axis_tdata,   // [31:0] image_word
  // Link words out
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [WordW-1:0]  m_axis_tdata,   // [31:0] link_word
  output logic      [KindW-1:0]  m_axis_tuser,   // [1:0] word_kind
  output logic                   m_axis_tlast    // last_of_run
);

  // Configuration registers
  logic [SizeW-1:0] image_bytes_q;
  logic [WordW-1:0] raw_key_q;
  logic             cfg_wr;

  // Session state
  logic [SizeW-1:0] offset_q, offset_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [WordW-1:0] key_q, key_d;

  // Result queue
  result_t          fifo_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  logic             in_fire, out_fire;
  logic [SizeW-1:0] clamped, send_size;
  logic             first, in_header, last;
  logic [WordW-1:0] key_base, key1, key2, key_mul1, key_mul2;
  logic [CrcW-1:0]  crc_base, crc1;
  logic [WordW-1:0] payload_word, seal_word, seal_plain;
  logic [SizeW:0]   off_plus4;
  result_t          res0, res1;
  logic             push_two;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_bytes_q <= SizeW'(MinImageBytes);
      raw_key_q     <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == AddrRawKey[2]) begin
        raw_key_q <= pwdata;
      end else begin
        image_bytes_q <= pwdata[SizeW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == AddrRawKey[2]) ? raw_key_q
                                                : {{(32-SizeW){1'b0}}, image_bytes_q};

  // ---------------- per-word datapath ----------------
  // Saturate the length into range, then round up to a multiple of eight
  always_comb begin
    clamped = image_bytes_q;
    if (clamped < SizeW'(MinImageBytes)) begin
      clamped = SizeW'(MinImageBytes);
    end
    if (clamped > SizeW'(MaxImageBytes)) begin
      clamped = SizeW'(MaxImageBytes);
    end
    send_size = (clamped + SizeW'(7)) & ~SizeW'(7);
  end

  assign first     = (offset_q == '0);
  assign in_header = (offset_q < SizeW'(HeaderBytes));
  assign off_plus4 = {1'b0, offset_q} + (SizeW+1)'(4);
  assign last      = (off_plus4 >= {1'b0, send_size});

  // Load the key and CRC at session start, otherwise carry them on
  assign key_base = first ? swap32(raw_key_q ^ KeyXor) : key_q;
  assign crc_base = first ? CrcInit : crc_q;

  // One and two LCG steps, each a single constant multiply from the base key
  assign key_mul1 = key_base * LcgMul;
  assign key_mul2 = key_base * LcgMul2;

  assign crc1 = in_header ? crc_base : crc_word(crc_base, s_axis_tdata);
  assign key1 = in_header ? key_base : key_mul1 + 32'd1;
  // The seal always follows a masked payload word, so it takes the second step
  assign key2 = key_mul2 + LcgAdd2;

  assign payload_word = s_axis_tdata ^ key1
                      ^ (~({{(WordW-SizeW){1'b0}}, offset_q} + AddrBase) + 32'd1)
                      ^ DataXor;
  assign seal_plain   = {send_size[15:0], crc1};
  assign seal_word    = seal_plain ^ key2
                      ^ (~({{(WordW-SizeW-1){1'b0}}, off_plus4} + AddrBase) + 32'd1)
                      ^ DataXor;

  always_comb begin
    res0     = '{word: payload_word, kind: KindPayload, last: 1'b1};
    res1     = '{word: seal_word, kind: KindSeal, last: 1'b1};
    push_two = 1'b0;
    if (first) begin
      res0     = '{word: swap32(handshake_key(send_size)), kind: KindKey, last: 1'b0};
      res1     = '{word: s_axis_tdata, kind: KindHeader, last: 1'b1};
      push_two = 1'b1;
    end else if (in_header) begin
      res0 = '{word: s_axis_tdata, kind: KindHeader, last: 1'b1};
    end else if (last) begin
      res0.last = 1'b0;
      push_two  = 1'b1;
    end
  end

  always_comb begin
    offset_d = last ? '0 : off_plus4[SizeW-1:0];
    crc_d    = crc1;
    key_d    = last ? key2 : key1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      crc_q    <= CrcInit;
      key_q    <= '0;
    end else if (in_fire) begin
      offset_q <= offset_d;
      crc_q    <= crc_d;
      key_q    <= key_d;
    end
  end

  // ---------------- result queue ----------------
  // Hold input off unless two entries are free, so a two-result word always fits
  assign s_axis_tready = (cnt_q <= CntW'(FifoDepth - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fifo_q[wr_ptr_q] <= res0;
      if (push_two) begin
        fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + (push_two ? PtrW'(2) : PtrW'(1));
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (in_fire ? (push_two ? CntW'(2) : CntW'(1)) : CntW'(0))
                     - (out_fire ? CntW'(1) : CntW'(0));
    end
  end

  assign m_axis_tdata = fifo_q[rd_ptr_q].word;
  assign m_axis_tuser = fifo_q[rd_ptr_q].kind;
  assign m_axis_tlast = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire
